### design/timed_event_priority_queue_defines.svh
// Assertion macros for the event queue checker.
`ifndef TIMED_EVENT_PRIORITY_QUEUE_DEFINES_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_DEFINES_SVH
`define TEPQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define TEPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### design/tepq_pkg.sv
`timescale 1ns / 1ps
package tepq_pkg;
  localparam int SOURCE_BITS = 8;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_POP = 2'd1,
    OP_CANCEL = 2'd2,
    OP_RESCHEDULE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL = 3'd2,
    ST_LATE = 3'd3,
    ST_PAST_END = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] source_id;
    logic [63:0] event_time;
  } cmd_t;

  typedef struct packed {
    logic [2:0] result_status;
    logic [7:0] result_source;
    logic [63:0] result_time;
    logic [63:0] current_time_out;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REMOVE,
    BK_INSERT,
    BK_DONE
  } back_state_t;
endpackage

### design/timed_event_priority_queue.sv
`timescale 1ns / 1ps
// A command accepted into the front buffer waits there while the back end
// finishes the previous word, then passes through the idle, remove, insert
// and done steps of the back end over the shift-register slot array; the
// front buffer can take a new command while the back end works on the last.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous reset empties the queue, clears current time and end time.
module timed_event_priority_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tepq_pkg::cmd_t    command,
  output logic              done,
  output tepq_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [63:0]       cfg_data
);
  import tepq_pkg::*;

  logic [63:0] end_time;
  logic q_valid, q_take;
  cmd_t q_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_time <= '0;
    end else if (cfg_valid && cfg_ready) begin
      end_time <= cfg_data;
    end
  end

  tepq_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .q_valid(q_valid), .q_word(q_word), .q_take(q_take)
  );

  tepq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .end_time(end_time), .q_valid(q_valid),
    .q_word(q_word), .q_take(q_take), .done(done), .result(result)
  );
endmodule

### design/tepq_front.sv
`timescale 1ns / 1ps
module tepq_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tepq_pkg::cmd_t  command,
  output logic            q_valid,
  output tepq_pkg::cmd_t  q_word,
  input  logic            q_take
);
  import tepq_pkg::*;

  cmd_t buf_word;
  logic buf_full;

  assign busy = buf_full;
  assign q_valid = buf_full;
  assign q_word = buf_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full <= 1'b0;
    end else if (start && !buf_full) begin
      buf_full <= 1'b1;
    end else if (q_take) begin
      buf_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !buf_full) begin
      buf_word <= command;
    end
  end
endmodule

### design/tepq_back.sv
`timescale 1ns / 1ps
module tepq_back #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [63:0]       end_time,
  input  logic              q_valid,
  input  tepq_pkg::cmd_t    q_word,
  output logic              q_take,
  output logic              done,
  output tepq_pkg::result_t result
);
  import tepq_pkg::*;

  logic [63:0] slot_time [QUEUE_DEPTH];
  logic [SOURCE_BITS-1:0] slot_source [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] slot_valid;
  logic [63:0] current_time;
  back_state_t state, state_next;
  cmd_t cmd;
  logic [QUEUE_DEPTH-1:0] hit, le, rm_mask, rm_above;
  logic found;
  status_t status;
  logic [7:0] rsrc;
  logic [63:0] rtime;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit[i] = slot_valid[i] && (slot_source[i] == cmd.source_id[SOURCE_BITS-1:0]);
      le[i] = slot_valid[i] && (slot_time[i] <= cmd.event_time);
    end
    rm_mask = hit & (~hit + 1'b1);
    if (cmd.opcode == OP_POP) begin
      rm_mask = '0;
      rm_mask[0] = slot_valid[0];
    end
    rm_above = rm_mask - 1'b1;
    rm_above = ~rm_above;
    found = |rm_mask;
  end

  assign q_take = (state == BK_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_REMOVE;
      BK_REMOVE: state_next = BK_INSERT;
      BK_INSERT: state_next = BK_DONE;
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      slot_valid <= '0;
      current_time <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        BK_IDLE: begin
          cmd <= q_word;
          status <= ST_OK;
          rsrc <= '0;
          rtime <= '0;
        end
        BK_REMOVE: begin
          if (cmd.opcode != OP_SCHEDULE) begin
            if (cmd.opcode == OP_POP && !found) status <= ST_EMPTY;
            if (cmd.opcode == OP_CANCEL && !found) status <= ST_NOT_FOUND;
            if (cmd.opcode == OP_POP && found) begin
              rsrc <= 8'(slot_source[0]);
              rtime <= slot_time[0];
              current_time <= slot_time[0];
            end
            if (found) begin
              for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (rm_above[i]) begin
                  slot_time[i] <= slot_time[i+1];
                  slot_source[i] <= slot_source[i+1];
                end
              end
              slot_valid <= slot_valid >> 1 | (slot_valid & ~rm_above);
            end
          end
        end
        BK_INSERT: begin
          if (cmd.opcode == OP_SCHEDULE || cmd.opcode == OP_RESCHEDULE) begin
            if (cmd.event_time < current_time) status <= ST_LATE;
            else if (end_time != '0 && cmd.event_time >= end_time) status <= ST_PAST_END;
            else if (slot_valid[QUEUE_DEPTH-1]) status <= ST_FULL;
            else begin
              if (!le[0]) begin
                slot_time[0] <= cmd.event_time;
                slot_source[0] <= cmd.source_id[SOURCE_BITS-1:0];
              end
              for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (!le[i]) begin
                  if (le[i-1]) begin
                    slot_time[i] <= cmd.event_time;
                    slot_source[i] <= cmd.source_id[SOURCE_BITS-1:0];
                  end else begin
                    slot_time[i] <= slot_time[i-1];
                    slot_source[i] <= slot_source[i-1];
                  end
                end
              end
              slot_valid <= {slot_valid[QUEUE_DEPTH-2:0], 1'b1};
            end
          end
        end
        BK_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    result.result_status = status;
    result.result_source = rsrc;
    result.result_time = rtime;
    result.current_time_out = current_time;
  end
endmodule

### design/tepq_checker.sv
`timescale 1ns / 1ps
`include "timed_event_priority_queue_defines.svh"
module tepq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input tepq_pkg::result_t result
);
  import tepq_pkg::*;

  `TEPQ_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `TEPQ_ASSERT_IMPL(a_status_range, clk, rst, done, result.result_status <= ST_NOT_FOUND)
  `TEPQ_ASSERT_IMPL(a_fail_zero, clk, rst, done && result.result_status != ST_OK,
    result.result_time == 64'd0)
  `TEPQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
endmodule

bind timed_event_priority_queue tepq_checker u_tepq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

### tb/sv/tb_timed_event_priority_queue.sv
`timescale 1ns / 1ps
module tb_timed_event_priority_queue;
  import tepq_pkg::*;

  typedef struct {
    logic [63:0] t;
    logic [7:0]  s;
  } pending_t;

  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t r;
  } row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_t        command;
  logic        done;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;

  pending_t    pending[$];
  result_t     expected_results[$];
  logic [63:0] now_time;
  logic [63:0] cutoff;
  int          errors;
  int          idle_pct;

  timed_event_priority_queue dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[timed_event_priority_queue] ERROR");
    $finish;
  end

  function automatic status_t insert_event(logic [7:0] s, logic [63:0] t);
    int pos;
    pending_t e;
    if (t < now_time) return ST_LATE;
    if (cutoff != 0 && t >= cutoff) return ST_PAST_END;
    if (pending.size() >= 64) return ST_FULL;
    pos = 0;
    while (pos < pending.size() && pending[pos].t <= t) pos++;
    e.t = t;
    e.s = s;
    pending.insert(pos, e);
    return ST_OK;
  endfunction

  function automatic bit drop_source(logic [7:0] s);
    for (int k = 0; k < pending.size(); k++) begin
      if (pending[k].s == s) begin
        pending.delete(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t queue_step(cmd_t c);
    result_t r;
    r = '0;
    r.result_status = ST_OK;
    case (opcode_t'(c.opcode))
      OP_SCHEDULE: r.result_status = insert_event(c.source_id, c.event_time);
      OP_POP: begin
        if (pending.size() == 0) begin
          r.result_status = ST_EMPTY;
        end else begin
          r.result_source = pending[0].s;
          r.result_time = pending[0].t;
          now_time = pending[0].t;
          pending.delete(0);
        end
      end
      OP_CANCEL: r.result_status = drop_source(c.source_id) ? ST_OK : ST_NOT_FOUND;
      default: begin
        void'(drop_source(c.source_id));
        r.result_status = insert_event(c.source_id, c.event_time);
      end
    endcase
    r.current_time_out = now_time;
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report("unexpected word", 64'(result.result_status), 64'd0);
      end else begin
        if (result.result_status != expected_results[0].result_status)
          report("status", 64'(result.result_status),
                 64'(expected_results[0].result_status));
        if (result.result_source != expected_results[0].result_source)
          report("source", 64'(result.result_source),
                 64'(expected_results[0].result_source));
        if (result.result_time != expected_results[0].result_time)
          report("time", result.result_time, expected_results[0].result_time);
        if (result.current_time_out != expected_results[0].current_time_out)
          report("current time", result.current_time_out,
                 expected_results[0].current_time_out);
        void'(expected_results.pop_front());
      end
    end
  end

  task automatic send(cmd_t c, bit typed, result_t want);
    int gap;
    result_t r;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    r = queue_step(c);
    expected_results.push_back(typed ? want : r);
  endtask

  task automatic write_cutoff(logic [63:0] v);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cutoff = v;
  endtask

  function automatic cmd_t random_cmd(bit grow);
    cmd_t c;
    int p;
    int w;
    p = $urandom_range(0, 99);
    if (grow) c.opcode = p < 50 ? OP_SCHEDULE : p < 65 ? OP_RESCHEDULE : p < 80 ? OP_CANCEL : OP_POP;
    else c.opcode = p < 20 ? OP_SCHEDULE : p < 30 ? OP_RESCHEDULE : p < 45 ? OP_CANCEL : OP_POP;
    c.source_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 15));
    w = $urandom_range(0, 99);
    if (w < 4 && cutoff != 0 && cutoff != '1)
      c.event_time = {$urandom, $urandom};
    else if (w < 10)
      c.event_time = now_time == 0 ? 64'd0 : now_time - 64'($urandom_range(1, 3));
    else if (w < 25 && pending.size() != 0)
      c.event_time = pending[$urandom_range(0, pending.size() - 1)].t;
    else
      c.event_time = now_time + 64'($urandom_range(0, 300));
    return c;
  endfunction

  row_t dir_rows[15] = '{
    '{'{OP_POP, 8'd0, 64'd0}, 1, '{ST_EMPTY, 8'd0, 64'd0, 64'd0}},
    '{'{OP_CANCEL, 8'd7, 64'd0}, 1, '{ST_NOT_FOUND, 8'd0, 64'd0, 64'd0}},
    '{'{OP_SCHEDULE, 8'd0, 64'd0}, 1, '{ST_OK, 8'd0, 64'd0, 64'd0}},
    '{'{OP_SCHEDULE, 8'hff, 64'hffff_ffff_ffff_ffff}, 1, '{ST_OK, 8'd0, 64'd0, 64'd0}},
    '{'{OP_SCHEDULE, 8'd3, 64'd10}, 0, '0},
    '{'{OP_SCHEDULE, 8'd4, 64'd10}, 0, '0},
    '{'{OP_POP, 8'd0, 64'd0}, 1, '{ST_OK, 8'd0, 64'd0, 64'd0}},
    '{'{OP_POP, 8'd0, 64'd0}, 1, '{ST_OK, 8'd3, 64'd10, 64'd10}},
    '{'{OP_SCHEDULE, 8'd5, 64'd9}, 1, '{ST_LATE, 8'd0, 64'd0, 64'd10}},
    '{'{OP_RESCHEDULE, 8'd4, 64'd20}, 0, '0},
    '{'{OP_RESCHEDULE, 8'd9, 64'd30}, 0, '0},
    '{'{OP_CANCEL, 8'hff, 64'd0}, 1, '{ST_OK, 8'd0, 64'd0, 64'd10}},
    '{'{OP_RESCHEDULE, 8'd9, 64'd5}, 0, '0},
    '{'{OP_POP, 8'd0, 64'd0}, 0, '0},
    '{'{OP_POP, 8'd0, 64'd0}, 1, '{ST_EMPTY, 8'd0, 64'd0, 64'd20}}
  };

  initial begin
    logic [63:0] cutoffs[5];
    int n;
    rst = 1'b1;
    start = 1'b0;
    command = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    now_time = '0;
    cutoff = '0;
    errors = 0;
    idle_pct = 22;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
    n = 0;
    for (int ph = 0; ph < 5; ph++) begin
      cutoffs = '{64'd0, 64'hffff_ffff_ffff_ffff, now_time + 64'd500, 64'd1, 64'd0};
      if (ph != 0) write_cutoff(cutoffs[ph]);
      for (int i = 0; i < 310; i++) begin
        idle_pct = n < 520 ? 22 : n < 1040 ? 50 : 0;
        send(random_cmd(((i / 80) % 2) == 0), 1'b0, '0);
        n++;
      end
    end
    @(posedge clk);
    start <= 1'b0;
    for (int w = 0; w < 5000 && expected_results.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[timed_event_priority_queue] OK");
    end else begin
      $display("[timed_event_priority_queue] ERROR");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/tepq_pkg.sv
design/tepq_front.sv
design/tepq_back.sv
design/timed_event_priority_queue.sv
design/tepq_checker.sv
tb/sv/tb_timed_event_priority_queue.sv
